/* rtl/fixed_capacity_multiset_top_defines.svh */
// Assertion helpers shared by the multiset RTL.
`ifndef FIXED_CAPACITY_MULTISET_TOP_DEFINES_SVH
`define FIXED_CAPACITY_MULTISET_TOP_DEFINES_SVH

// Checked on every rising edge, ignored while reset is held.
`define FCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/fcm_pkg.sv */
package fcm_pkg;

  // Default sizes
  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Port field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned CNT_OUT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_UQ = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_ACT  = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch a new item, restart scan
    logic scan;      // issue read of the next stored entry
    logic act;       // apply the operation
    logic move;      // write the last entry into the removed slot
    logic out_load;  // capture the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic issue_done; // every stored entry has been read
    logic scan_done;  // ... and the last compare has landed
    logic need_move;  // remove found its value
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

/* rtl/fcm_ram.sv */
module fcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/fcm_ctrl.sv */
`include "fixed_capacity_multiset_top_defines.svh"

module fcm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fcm_pkg::sts_t sts_i,
  output fcm_pkg::cmd_t cmd_o
);

  import fcm_pkg::*;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = !sts_i.issue_done;
        if (sts_i.scan_done) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        cmd_o.act = 1'b1;
        state_d   = sts_i.need_move ? ST_MOVE : ST_DONE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FCM_ASSERT(a_move_after_act, (state_q == ST_MOVE) |-> $past(state_q == ST_ACT), "move without act")
  `FCM_ASSERT(a_act_after_scan, (state_q == ST_ACT) |-> sts_i.scan_done, "act before scan end")
  `FCM_ASSERT(a_result_then_idle, cmd_o.out_load |=> (state_q == ST_IDLE), "no idle after result")

endmodule

/* rtl/fcm_dp.sv */
`include "fixed_capacity_multiset_top_defines.svh"

module fcm_dp #(
  parameter int unsigned CAPACITY    = fcm_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = fcm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [fcm_pkg::OP_W-1:0]        op_i,
  input  logic [fcm_pkg::IN_VAL_W-1:0]    item_value_i,
  input  fcm_pkg::cmd_t                   cmd_i,
  output fcm_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            success_o,
  output logic [fcm_pkg::CNT_OUT_W-1:0]   frequency_o,
  output logic [fcm_pkg::CNT_OUT_W-1:0]   size_o
);

  import fcm_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] in_val;
  logic [OP_W-1:0]        op_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q;
  logic [CW-1:0]          freq_q;
  logic                   found_q;
  logic                   pend_q;
  logic [AW-1:0]          pidx_q;
  logic [AW-1:0]          first_q;
  logic                   ok_q, ok_d;
  logic                   out_valid_q;
  logic                   out_success_q;
  logic [CW-1:0]          out_freq_q, out_size_q;
  logic [CW+4:0]          freq_ext, size_ext;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata, rd_data;
  logic                   room, hit;
  logic [AW-1:0]          last_idx;

  // Input value reduced or widened to the stored width
  if (VALUE_WIDTH <= IN_VAL_W) begin : g_val_narrow
    assign in_val = item_value_i[VALUE_WIDTH-1:0];
  end else begin : g_val_wide
    assign in_val = {{(VALUE_WIDTH - IN_VAL_W){1'b0}}, item_value_i};
  end

  fcm_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign room     = count_q < CW'(CAPACITY);
  assign hit      = pend_q && (rd_data == value_q);
  assign last_idx = AW'(count_q - CW'(1));

  // Status to controller
  assign sts_o.issue_done = (idx_q == count_q);
  assign sts_o.scan_done  = (idx_q == count_q) && !pend_q;
  assign sts_o.need_move  = (op_q == OP_REMOVE) && found_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Operation apply and store write port
  always_comb begin
    we      = 1'b0;
    waddr   = count_q[AW-1:0];
    wdata   = value_q;
    raddr   = idx_q[AW-1:0];
    count_d = count_q;
    ok_d    = ok_q;
    if (cmd_i.act) begin
      raddr = last_idx;
      unique case (op_q)
        OP_ADD: begin
          ok_d = room;
          if (room) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OP_ADD_UQ: begin
          ok_d = room && (freq_q == '0);
          if (room && (freq_q == '0)) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OP_REMOVE: ok_d = found_q;
        OP_COUNT:  ok_d = (freq_q != '0);
        OP_CLEAR: begin
          ok_d    = 1'b1;
          count_d = '0;
        end
        default:   ok_d = 1'b0;
      endcase
    end
    if (cmd_i.move) begin
      we      = 1'b1;
      waddr   = first_q;
      wdata   = rd_data;
      count_d = count_q - CW'(1);
    end
  end

  // Control state and scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      freq_q      <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= cmd_i.scan;
      if (cmd_i.load) begin
        idx_q   <= '0;
        freq_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          idx_q <= idx_q + CW'(1);
        end
        if (hit) begin
          freq_q  <= freq_q + CW'(1);
          found_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and result
  always_ff @(posedge clk_i) begin
    pidx_q <= idx_q[AW-1:0];
    ok_q   <= ok_d;
    if (cmd_i.load) begin
      op_q    <= op_i;
      value_q <= in_val;
    end
    if (hit && !found_q) begin
      first_q <= pidx_q;
    end
    if (cmd_i.out_load) begin
      out_success_q <= ok_q;
      out_freq_q    <= freq_q;
      out_size_q    <= count_q;
    end
  end

  // Counts are reported in their low five bits
  assign freq_ext    = {5'b0, out_freq_q};
  assign size_ext    = {5'b0, out_size_q};
  assign out_valid_o = out_valid_q;
  assign success_o   = out_success_q;
  assign frequency_o = freq_ext[CNT_OUT_W-1:0];
  assign size_o      = size_ext[CNT_OUT_W-1:0];

  `FCM_ASSERT(a_count_cap, count_q <= CW'(CAPACITY), "entry count above capacity")
  `FCM_ASSERT(a_freq_le_idx, freq_q <= idx_q, "more matches than entries read")
  `FCM_ASSERT(a_move_slot, cmd_i.move |-> (found_q && (CW'(first_q) < count_q)), "bad move slot")

endmodule

/* rtl/fixed_capacity_multiset_top.sv */
// Multiset (bag) of up to CAPACITY values in a dense on-chip store with a fill
// count. Each item carries an op (add, add if absent, remove one, count, clear)
// and a value; every item gives one result with success, the value's frequency
// before the op and the size after it. An accepted item is first compared with
// every stored entry, then its op is applied; a remove that finds its value
// also writes the last entry into the freed slot before the result is loaded.
// The store has one registered read port and the scan reads one entry per
// cycle. One item is in work at a time; a finished result waits in an output
// register while the next item is accepted, and a result not yet taken holds
// the next one back.
module fixed_capacity_multiset_top #(
  parameter int unsigned CAPACITY    = fcm_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = fcm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fcm_pkg::OP_W-1:0]      op_i,
  input  logic [fcm_pkg::IN_VAL_W-1:0]  item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          success_o,
  output logic [fcm_pkg::CNT_OUT_W-1:0] frequency_o,
  output logic [fcm_pkg::CNT_OUT_W-1:0] size_o
);

  import fcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcm_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .item_value_i (item_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .success_o    (success_o),
    .frequency_o  (frequency_o),
    .size_o       (size_o)
  );

endmodule
